// ----- hw/rtl/difference_constraint_feasibility_assert.svh -----
// Assertion macros shared by the RTL.
`ifndef DIFFERENCE_CONSTRAINT_FEASIBILITY_ASSERT_SVH
`define DIFFERENCE_CONSTRAINT_FEASIBILITY_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define DCF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define DCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/dcf_pkg.sv -----
package dcf_pkg;

  // Vertex index width of the edge fields.
  localparam int unsigned VIDX_BITS = 6;
  // Width of the vertex_count register.
  localparam int unsigned VCNT_BITS = 7;
  localparam logic [VCNT_BITS-1:0] VCNT_RESET = 7'd64;

  // Error codes reported with the verdict.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_RANGE    = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_CLEAR = 7'b0000100,
    S_FETCH = 7'b0001000,
    S_READ  = 7'b0010000,
    S_ADD   = 7'b0100000,
    S_CMP   = 7'b1000000
  } dcf_state_e;

  // Status of one relaxation, valid in the compare cycle.
  typedef struct packed {
    logic update;  // candidate beats the stored target distance
    logic sat;     // candidate was clamped to the distance range
  } dcf_relax_res_t;

endpackage

// ----- hw/rtl/difference_constraint_feasibility.sv -----
// Difference-constraint feasibility (Bellman-Ford negative-cycle check).
// Edges are sent one per start pulse and load at one per cycle while busy
// is low. The edge with last_edge set is stored too and starts evaluation:
// busy rises, and when the verdict is ready done_o pulses for exactly one
// cycle with feasible_o and error_code_o. busy stays high through that
// result cycle, so the next set starts on a cleared store. There is no
// back-pressure on the result: the receiver must take it in that cycle.
// Evaluation runs a check step, clears the nv distances, then makes
// relaxation passes over the E stored edges (up to nv passes, stopping
// after a pass with no change or at a negative cycle), and ends in the
// result cycle, where nv is vertex_count clamped to 1..MAX_VERTICES.
// Each edge takes four steps: edge-store read, distance read,
// add/saturate, compare/write-back on the one-read-port memories.
// An error (store overflow or a vertex at or above nv) skips the passes.
// vertex_count is written through the cfg channel while the block is idle.
module difference_constraint_feasibility #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_EDGES    = 256,
  parameter int unsigned WEIGHT_BITS  = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // edge command channel
  input  logic                              start,
  output logic                              busy,
  input  logic [dcf_pkg::VIDX_BITS-1:0]     edge_source_i,
  input  logic [dcf_pkg::VIDX_BITS-1:0]     edge_target_i,
  input  logic signed [WEIGHT_BITS-1:0]     edge_weight_i,
  input  logic                              last_edge_i,
  // verdict strobe
  output logic                              done_o,
  output logic                              feasible_o,
  output logic [1:0]                        error_code_o,
  // vertex_count write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dcf_pkg::VCNT_BITS-1:0]     cfg_data_i
);

  import dcf_pkg::*;

  localparam int unsigned DIST_BITS = (WEIGHT_BITS + 8 > 63) ? 63 : WEIGHT_BITS + 8;
  localparam int unsigned EDGE_BITS = 2 * VIDX_BITS + WEIGHT_BITS;
  localparam int unsigned EAW       = $clog2(MAX_EDGES);
  localparam int unsigned ETW       = $clog2(MAX_EDGES + 1);
  localparam int unsigned VW        = $clog2(MAX_VERTICES);

  // FSM and control registers
  dcf_state_e           state_q, state_d;
  logic [VCNT_BITS-1:0] vcount_q;
  logic [ETW-1:0]       edge_total_q, edge_total_d;
  logic [VIDX_BITS-1:0] maxv_q, maxv_d;
  logic [1:0]           err_q, err_d;
  logic                 feas_q, feas_d;
  logic                 done_q, done_d;
  logic [VCNT_BITS-1:0] nv_q, nv_d;
  logic [VCNT_BITS-1:0] clr_q, clr_d;
  logic [VCNT_BITS-1:0] pass_q, pass_d;
  logic [EAW-1:0]       idx_q, idx_d;
  logic                 changed_q, changed_d;

  logic                 accept;
  logic                 store_full;
  logic [VCNT_BITS-1:0] nv_eff;
  logic [VIDX_BITS-1:0] in_maxv;
  logic [ETW-1:0]       idx_next;

  // memory ports
  logic                 edge_we;
  logic                 edge_re;
  logic [EDGE_BITS-1:0] edge_rdata;
  logic [VIDX_BITS-1:0] e_src;
  logic [VIDX_BITS-1:0] e_dst;
  logic [WEIGHT_BITS-1:0] e_w;
  logic                 dist_we;
  logic [VW-1:0]        dist_waddr;
  logic [DIST_BITS-1:0] dist_wdata;
  logic                 dist_re;
  logic [DIST_BITS-1:0] dist_src_rdata;
  logic [DIST_BITS-1:0] dist_dst_rdata;

  logic                 relax_load;
  logic [DIST_BITS-1:0] cand;
  dcf_relax_res_t       relax_res;

  // the result cycle counts as busy: the set is cleared during it
  assign busy        = (state_q != S_IDLE) || done_q;
  assign accept      = start && !busy;
  assign cfg_ready_o = !busy;
  assign done_o      = done_q;
  assign feasible_o  = feas_q;
  assign error_code_o = err_q;

  assign store_full = edge_total_q == ETW'(MAX_EDGES);
  assign in_maxv    = (edge_source_i > edge_target_i) ? edge_source_i : edge_target_i;
  assign idx_next   = ETW'(idx_q) + ETW'(1);

  // vertex_count 0 acts as 1, above MAX_VERTICES acts as MAX_VERTICES
  always_comb begin
    if (vcount_q == '0) begin
      nv_eff = VCNT_BITS'(1);
    end else if (32'(vcount_q) > MAX_VERTICES) begin
      nv_eff = VCNT_BITS'(MAX_VERTICES);
    end else begin
      nv_eff = vcount_q;
    end
  end

  // stored edge layout: source, target, weight
  assign e_src = edge_rdata[EDGE_BITS-1 -: VIDX_BITS];
  assign e_dst = edge_rdata[WEIGHT_BITS +: VIDX_BITS];
  assign e_w   = edge_rdata[WEIGHT_BITS-1:0];

  assign edge_we    = accept && !store_full;
  assign edge_re    = state_q == S_FETCH;
  assign dist_re    = state_q == S_READ;
  assign relax_load = state_q == S_ADD;

  always_comb begin
    state_d      = state_q;
    edge_total_d = edge_total_q;
    maxv_d       = maxv_q;
    err_d        = err_q;
    feas_d       = feas_q;
    done_d       = 1'b0;
    nv_d         = nv_q;
    clr_d        = clr_q;
    pass_d       = pass_q;
    idx_d        = idx_q;
    changed_d    = changed_q;
    dist_we      = 1'b0;
    dist_waddr   = VW'(clr_q);
    dist_wdata   = '0;

    unique case (state_q)
      S_IDLE: begin
        // the verdict strobe leaves the set cleared behind it
        if (done_q) begin
          edge_total_d = '0;
          maxv_d       = '0;
          err_d        = ERR_NONE;
        end
        if (accept) begin
          if (!store_full) begin
            edge_total_d = edge_total_q + ETW'(1);
            if (in_maxv > maxv_q) begin
              maxv_d = in_maxv;
            end
          end else if (err_q == ERR_NONE) begin
            err_d = ERR_OVERFLOW;
          end
          if (last_edge_i) begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        // range test uses vertex_count as it stands now
        nv_d = nv_eff;
        if (err_q != ERR_NONE) begin
          feas_d  = 1'b0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (edge_total_q == '0) begin
          feas_d  = 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if ({1'b0, maxv_q} >= nv_eff) begin
          err_d   = ERR_RANGE;
          feas_d  = 1'b0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          clr_d   = '0;
          state_d = S_CLEAR;
        end
      end
      S_CLEAR: begin
        dist_we = 1'b1;
        if (clr_q == nv_q - VCNT_BITS'(1)) begin
          idx_d     = '0;
          pass_d    = '0;
          changed_d = 1'b0;
          state_d   = S_FETCH;
        end else begin
          clr_d = clr_q + VCNT_BITS'(1);
        end
      end
      S_FETCH: begin
        state_d = S_READ;
      end
      S_READ: begin
        state_d = S_ADD;
      end
      S_ADD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        dist_waddr = VW'(e_dst);
        dist_wdata = cand;
        if (relax_res.update && (relax_res.sat || pass_q == nv_q - VCNT_BITS'(1))) begin
          // a change in the final pass, or a clamped sum: negative cycle
          dist_we = 1'b1;
          feas_d  = 1'b0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          dist_we = relax_res.update;
          state_d = S_FETCH;
          if (idx_next == edge_total_q) begin
            idx_d     = '0;
            changed_d = 1'b0;
            if (!(changed_q || relax_res.update)) begin
              feas_d  = 1'b1;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              pass_d = pass_q + VCNT_BITS'(1);
            end
          end else begin
            idx_d     = idx_q + EAW'(1);
            changed_d = changed_q || relax_res.update;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      vcount_q     <= VCNT_RESET;
      edge_total_q <= '0;
      maxv_q       <= '0;
      err_q        <= ERR_NONE;
      feas_q       <= 1'b0;
      done_q       <= 1'b0;
      nv_q         <= VCNT_BITS'(1);
      clr_q        <= '0;
      pass_q       <= '0;
      idx_q        <= '0;
      changed_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      edge_total_q <= edge_total_d;
      maxv_q       <= maxv_d;
      err_q        <= err_d;
      feas_q       <= feas_d;
      done_q       <= done_d;
      nv_q         <= nv_d;
      clr_q        <= clr_d;
      pass_q       <= pass_d;
      idx_q        <= idx_d;
      changed_q    <= changed_d;
      if (cfg_valid_i && cfg_ready_o) begin
        vcount_q <= cfg_data_i;
      end
    end
  end

  // edge store, appended in arrival order
  dcf_ram #(
    .WIDTH (EDGE_BITS),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_total_q[EAW-1:0]),
    .wdata_i ({edge_source_i, edge_target_i, edge_weight_i}),
    .re_i    (edge_re),
    .raddr_i (idx_q),
    .rdata_o (edge_rdata)
  );

  // two copies of the distances, written together, read at source and target
  dcf_ram #(
    .WIDTH (DIST_BITS),
    .DEPTH (MAX_VERTICES)
  ) u_dist_src_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .re_i    (dist_re),
    .raddr_i (VW'(e_src)),
    .rdata_o (dist_src_rdata)
  );

  dcf_ram #(
    .WIDTH (DIST_BITS),
    .DEPTH (MAX_VERTICES)
  ) u_dist_dst_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .re_i    (dist_re),
    .raddr_i (VW'(e_dst)),
    .rdata_o (dist_dst_rdata)
  );

  // add/saturate in S_ADD, compare in S_CMP; edge read data holds meanwhile
  dcf_relax #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .DIST_BITS   (DIST_BITS)
  ) u_relax (
    .clk_i      (clk_i),
    .load_i     (relax_load),
    .dist_src_i (dist_src_rdata),
    .dist_dst_i (dist_dst_rdata),
    .weight_i   (e_w),
    .cand_o     (cand),
    .res_o      (relax_res)
  );

`include "difference_constraint_feasibility_assert.svh"

  `DCF_ASSERT_NEXT(a_last_edge_busy, start && !busy && last_edge_i, busy, "last edge did not start evaluation")
  `DCF_ASSERT_NEXT(a_done_idle, done_o, !busy && edge_total_q == '0, "set not cleared after verdict")
  `DCF_ASSERT_SAME(a_err_infeasible, done_o && error_code_o != ERR_NONE, !feasible_o, "error verdict reported feasible")
  `DCF_ASSERT_SAME(a_total_bound, 1'b1, 32'(edge_total_q) <= MAX_EDGES, "edge count beyond store depth")

endmodule

// ----- hw/rtl/dcf_ram.sv -----
module dcf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/dcf_relax.sv -----
module dcf_relax #(
  parameter int unsigned WEIGHT_BITS = 48,
  parameter int unsigned DIST_BITS   = 56
) (
  input  logic                           clk_i,
  input  logic                           load_i,
  input  logic [DIST_BITS-1:0]           dist_src_i,
  input  logic [DIST_BITS-1:0]           dist_dst_i,
  input  logic [WEIGHT_BITS-1:0]         weight_i,
  output logic [DIST_BITS-1:0]           cand_o,
  output dcf_pkg::dcf_relax_res_t        res_o
);

  import dcf_pkg::*;

  logic signed [DIST_BITS:0]   sum;
  logic                        sat;
  logic [DIST_BITS-1:0]        cand;
  logic signed [DIST_BITS-1:0] cand_q;
  logic signed [DIST_BITS-1:0] ddst_q;
  logic                        sat_q;

  // One extra bit holds any sum; the top two bits disagree on overflow.
  assign sum = $signed({dist_src_i[DIST_BITS-1], dist_src_i})
             + $signed({{(DIST_BITS + 1 - WEIGHT_BITS){weight_i[WEIGHT_BITS-1]}}, weight_i});
  assign sat = sum[DIST_BITS] != sum[DIST_BITS-1];

  always_comb begin
    if (!sat) begin
      cand = sum[DIST_BITS-1:0];
    end else if (sum[DIST_BITS]) begin
      cand = {1'b1, {(DIST_BITS - 1){1'b0}}};
    end else begin
      cand = {1'b0, {(DIST_BITS - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cand_q <= $signed(cand);
      ddst_q <= $signed(dist_dst_i);
      sat_q  <= sat;
    end
  end

  assign cand_o       = cand_q;
  assign res_o.update = ddst_q > cand_q;
  assign res_o.sat    = sat_q;

endmodule

// ----- sim/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dcf_pkg::*;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned MAX_EDGES    = 256;
  localparam int unsigned WEIGHT_BITS  = 48;
  // Distances carry 8 bits of headroom above the weight width.
  localparam int unsigned DIST_BITS    = (WEIGHT_BITS + 8 > 63) ? 63 : WEIGHT_BITS + 8;
  localparam longint DIST_MAX = longint'((64'd1 << (DIST_BITS - 1)) - 64'd1);
  localparam longint DIST_MIN = -DIST_MAX - 1;

  localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

  // Watchdog limit, set above the longest legal evaluation.
  localparam int unsigned WATCHDOG_LIMIT = 300000;
  localparam int unsigned PHASE_ITEMS    = 105;

  typedef struct {
    logic [VIDX_BITS-1:0]          src;
    logic [VIDX_BITS-1:0]          dst;
    logic signed [WEIGHT_BITS-1:0] weight;
    logic                          last;
  } edge_cmd_t;

  typedef struct {
    logic       feasible;
    logic [1:0] code;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Every DUT input starts at a known value.
  logic                          start         = 1'b0;
  logic [VIDX_BITS-1:0]          edge_source_i = '0;
  logic [VIDX_BITS-1:0]          edge_target_i = '0;
  logic signed [WEIGHT_BITS-1:0] edge_weight_i = '0;
  logic                          last_edge_i   = 1'b0;
  logic                          cfg_valid_i   = 1'b0;
  logic [VCNT_BITS-1:0]          cfg_data_i    = '0;

  logic       busy;
  logic       done_o;
  logic       feasible_o;
  logic [1:0] error_code_o;
  logic       cfg_ready_o;

  difference_constraint_feasibility #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .edge_source_i (edge_source_i),
    .edge_target_i (edge_target_i),
    .edge_weight_i (edge_weight_i),
    .last_edge_i   (last_edge_i),
    .done_o        (done_o),
    .feasible_o    (feasible_o),
    .error_code_o  (error_code_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Edges waiting to be sent, and verdicts predicted but not yet seen.
  edge_cmd_t edge_queue[$];
  verdict_t  verdict_queue[$];

  int error_count   = 0;
  int verdict_index = 0;

  // ---------------------------------------------------------------------------
  // Shadow of the block: edge store, error latch, vertex_count, distances.
  // ---------------------------------------------------------------------------
  logic [VIDX_BITS-1:0] stored_src    [MAX_EDGES];
  logic [VIDX_BITS-1:0] stored_dst    [MAX_EDGES];
  longint               stored_weight [MAX_EDGES];
  int unsigned          stored_count  = 0;
  logic [1:0]           pending_error = ERR_NONE;
  logic [VCNT_BITS-1:0] vertex_count_cfg = VCNT_RESET;
  longint               path_len [MAX_VERTICES];

  // 0 behaves as 1, anything past the vertex table as the full table.
  function automatic int unsigned clamp_vertices(input logic [VCNT_BITS-1:0] vc);
    if (vc == 0) return 1;
    if (vc > MAX_VERTICES) return MAX_VERTICES;
    return vc;
  endfunction

  // Bellman-Ford from a virtual source: all distances start at zero, relaxations
  // apply in place, early exit on a quiet pass. Any update in the last pass, or
  // a clamped candidate that still wins, means a negative cycle.
  function automatic logic relax_passes(input int unsigned nv);
    longint cand;
    bit     changed;
    bit     clipped;
    for (int v = 0; v < MAX_VERTICES; v++) path_len[v] = 0;
    for (int p = 0; p < nv; p++) begin
      changed = 0;
      for (int e = 0; e < stored_count; e++) begin
        cand    = path_len[stored_src[e]] + stored_weight[e];
        clipped = 0;
        if (cand < DIST_MIN) begin
          cand    = DIST_MIN;
          clipped = 1;
        end
        if (cand > DIST_MAX) begin
          cand    = DIST_MAX;
          clipped = 1;
        end
        if (path_len[stored_dst[e]] > cand) begin
          path_len[stored_dst[e]] = cand;
          changed = 1;
          if (clipped || p == nv - 1) return 1'b0;
        end
      end
      if (!changed) break;
    end
    return 1'b1;
  endfunction

  // Fold one accepted edge into the shadow; a last edge yields one verdict.
  function automatic void absorb_edge(input logic [VIDX_BITS-1:0] s,
                                      input logic [VIDX_BITS-1:0] d,
                                      input logic signed [WEIGHT_BITS-1:0] w,
                                      input logic last);
    verdict_t    v;
    int unsigned nv;
    if (stored_count < MAX_EDGES) begin
      stored_src[stored_count]    = s;
      stored_dst[stored_count]    = d;
      stored_weight[stored_count] = w;
      stored_count++;
    end else if (pending_error == ERR_NONE) begin
      pending_error = ERR_OVERFLOW;
    end
    if (!last) return;
    // range test uses the vertex_count in force at evaluation time
    nv = clamp_vertices(vertex_count_cfg);
    if (pending_error == ERR_NONE) begin
      for (int i = 0; i < stored_count; i++) begin
        if (stored_src[i] >= nv || stored_dst[i] >= nv) begin
          pending_error = ERR_RANGE;
          break;
        end
      end
    end
    v.code     = pending_error;
    v.feasible = (pending_error == ERR_NONE) ? relax_passes(nv) : 1'b0;
    verdict_queue = {verdict_queue, v};
    stored_count  = 0;
    pending_error = ERR_NONE;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: verdict %0d: %s", $time, verdict_index, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of edges with random gaps. A slot frees up when nothing is
  // offered or the offered edge transfers at this edge.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin : edge_driver
    edge_cmd_t nxt;
    if (rst_ni && (!start || !busy)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (edge_queue.size() != 0) begin
        nxt = edge_queue.pop_front();
        start         <= 1'b1;
        edge_source_i <= nxt.src;
        edge_target_i <= nxt.dst;
        edge_weight_i <= nxt.weight;
        last_edge_i   <= nxt.last;
        if (burst_left <= 1) begin
          // mostly short gaps, sometimes a long one, sometimes back-to-back
          case ($urandom_range(0, 7))
            0:       begin
                       burst_left <= $urandom_range(20, 60);
                       gap_left   <= 0;
                     end
            1:       begin
                       burst_left <= $urandom_range(1, 8);
                       gap_left   <= $urandom_range(10, 40);
                     end
            default: begin
                       burst_left <= $urandom_range(1, 16);
                       gap_left   <= $urandom_range(0, 5);
                     end
          endcase
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each verdict strobe, then folds in any edge or register
  // transfer seen at this edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : verdict_monitor
    verdict_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (verdict_queue.size() == 0) begin
          report_mismatch("verdict with no pending edge set");
        end else begin
          want = verdict_queue.pop_front();
          if (feasible_o !== want.feasible)
            report_mismatch($sformatf("feasible got %b want %b", feasible_o, want.feasible));
          if (error_code_o !== want.code)
            report_mismatch($sformatf("error_code got %0d want %0d", error_code_o, want.code));
        end
        verdict_index++;
      end
      if (cfg_valid_i && cfg_ready_o) vertex_count_cfg = cfg_data_i;
      if (start && !busy) absorb_edge(edge_source_i, edge_target_i, edge_weight_i, last_edge_i);
    end
  end

  // Watchdog: any transfer restarts the count.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_edge(input int unsigned s, input int unsigned d,
                                     input logic signed [WEIGHT_BITS-1:0] w,
                                     input bit last);
    edge_cmd_t c;
    c.src    = s[VIDX_BITS-1:0];
    c.dst    = d[VIDX_BITS-1:0];
    c.weight = w;
    c.last   = last;
    edge_queue = {edge_queue, c};
  endfunction

  // Small weights make cycles near zero total likely; some mid, some full range.
  function automatic logic signed [WEIGHT_BITS-1:0] pick_weight();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return WEIGHT_BITS'(int'($urandom_range(0, 24)) - 12);
    if (r < 9) return WEIGHT_BITS'(int'($urandom_range(0, 2000)) - 1000);
    return WEIGHT_BITS'({$urandom, $urandom});
  endfunction

  // One random edge set; returns the number of edges queued.
  function automatic int unsigned queue_random_set(input int unsigned nv);
    int unsigned n;
    int unsigned kind;
    int unsigned stray_at;
    int unsigned s;
    int unsigned d;
    int unsigned v0;
    int unsigned prev;
    int unsigned nxt;
    longint      sum;
    logic signed [WEIGHT_BITS-1:0] w;
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      // well-formed set, a share of them with one endpoint past nv
      n = $urandom_range(1, 10);
      stray_at = (kind >= 66 && nv < MAX_VERTICES) ? $urandom_range(0, n - 1) : n;
      for (int i = 0; i < n; i++) begin
        s = $urandom_range(0, nv - 1);
        d = $urandom_range(0, nv - 1);
        if (i == stray_at) begin
          if ($urandom_range(0, 1)) s = $urandom_range(nv, MAX_VERTICES - 1);
          else                      d = $urandom_range(nv, MAX_VERTICES - 1);
        end
        queue_edge(s, d, pick_weight(), i == n - 1);
      end
    end else if (kind < 92) begin
      // closed cycle whose total weight is -1, 0 or +1: right at the threshold
      n    = $urandom_range(1, (nv < 6) ? nv : 6);
      v0   = $urandom_range(0, nv - 1);
      prev = v0;
      sum  = 0;
      for (int i = 0; i < n; i++) begin
        nxt = (i == n - 1) ? v0 : $urandom_range(0, nv - 1);
        if (i == n - 1) begin
          w = WEIGHT_BITS'(longint'(int'($urandom_range(0, 2)) - 1) - sum);
        end else begin
          w = WEIGHT_BITS'(int'($urandom_range(0, 2000)) - 1000);
          sum += w;
        end
        queue_edge(prev, nxt, w, i == n - 1);
        prev = nxt;
      end
    end else begin
      // noise: any endpoint, any weight
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        queue_edge($urandom_range(0, MAX_VERTICES - 1), $urandom_range(0, MAX_VERTICES - 1),
                   WEIGHT_BITS'({$urandom, $urandom}), i == n - 1);
    end
    return n;
  endfunction

  // A long set; past MAX_EDGES it overflows the store.
  function automatic void queue_bulk_set(input int unsigned count, input int unsigned nv);
    for (int i = 0; i < count; i++)
      queue_edge($urandom_range(0, nv - 1), $urandom_range(0, nv - 1), pick_weight(),
                 i == count - 1);
  endfunction

  task automatic write_vertex_count(input logic [VCNT_BITS-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold the sender until every queued edge has transferred and every verdict
  // is in, then let the block settle.
  task automatic wait_idle();
    while (edge_queue.size() != 0 || start || verdict_queue.size() != 0 || busy)
      @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  logic [VCNT_BITS-1:0] vc_plan [10];

  initial begin
    int unsigned phase_items;
    int unsigned nv;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed sets on four vertices.
    write_vertex_count(7'd4);
    queue_edge(0, 0, 0, 1);                  // zero self loop: feasible
    queue_edge(1, 1, -1, 1);                 // negative self loop
    queue_edge(0, 1, 5, 0);                  // cycle of total zero
    queue_edge(1, 0, -5, 1);
    queue_edge(0, 1, 5, 0);                  // cycle of total -1
    queue_edge(1, 0, -6, 1);
    queue_edge(0, 3, W_MAX, 0);              // extreme weights, no cycle
    queue_edge(3, 2, W_MIN, 1);
    queue_edge(2, 3, 1, 0);                  // endpoint equal to nv
    queue_edge(3, 4, 0, 1);
    queue_edge(3, 3, W_MIN, 1);              // most negative self loop
    queue_edge(2, 2, W_MAX, 1);              // most positive self loop
    wait_idle();

    // Eight most-negative self loops on the top vertex drive the distance
    // into saturation well before the last pass.
    write_vertex_count(7'd127);
    for (int i = 0; i < 8; i++) queue_edge(63, 63, W_MIN, i == 7);
    wait_idle();

    vc_plan = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd5, 7'd127, 7'd16, 7'd3,
                7'($urandom_range(6, 63)), 7'($urandom_range(0, 127))};
    for (int p = 0; p < 10; p++) begin
      write_vertex_count(vc_plan[p]);
      nv = clamp_vertices(vc_plan[p]);
      phase_items = 0;
      // exact-fit store, then an overflowing set mixed with stray endpoints
      if (vc_plan[p] == 7'd2) queue_bulk_set(MAX_EDGES, nv);
      if (vc_plan[p] == 7'd5) queue_bulk_set(MAX_EDGES + 4, MAX_VERTICES);
      while (phase_items < PHASE_ITEMS) phase_items += queue_random_set(nv);
      wait_idle();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
